### rtl/tksc_pkg.sv
// ----------------------------------------------------------------------------
// tksc_pkg
// Shared constants and types for the top-k sum threshold check.
// ----------------------------------------------------------------------------
package tksc_pkg;

  localparam int unsigned MAX_SLOTS_DEF   = 8;
  localparam int unsigned WEIGHT_BITS_DEF = 16;

  localparam int unsigned CAP_BITS      = 24;
  localparam int unsigned SLOT_BITS     = 4;
  localparam int unsigned KEPT_SUM_BITS = 19;
  localparam int unsigned CFG_IDX_BITS  = 2;
  localparam int unsigned CFG_DATA_BITS = 24;
  localparam int unsigned M_DATA_BITS   = 24;

  localparam logic [CAP_BITS-1:0]     CAPACITY_RST = 24'hFF_FFFF;
  localparam logic [SLOT_BITS-1:0]    SLOTS_RST    = 4'd8;
  localparam logic [CFG_IDX_BITS-1:0] REG_CAPACITY = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_SLOTS    = 2'd1;

  typedef struct packed {
    logic load;   // absorb a weight this cycle
    logic shift;  // drain: shift store toward the tail
  } cell_ctrl_t;

endpackage

### rtl/tksc_cell.sv
// ----------------------------------------------------------------------------
// tksc_cell
// One slot of the sorted store: compare, insert or shift from its neighbor.
// ----------------------------------------------------------------------------
module tksc_cell #(
  parameter int unsigned WEIGHT_BITS = tksc_pkg::WEIGHT_BITS_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  tksc_pkg::cell_ctrl_t   ctrl_i,
  input  logic                   active_i,
  input  logic [WEIGHT_BITS-1:0] weight_i,
  input  logic [WEIGHT_BITS-1:0] prev_val_i,
  input  logic                   prev_lt_i,
  output logic [WEIGHT_BITS-1:0] val_o,
  output logic                   lt_o
);

  logic [WEIGHT_BITS-1:0] val_q, val_d;

  assign lt_o  = (val_q < weight_i);
  assign val_o = val_q;

  always_comb begin
    val_d = val_q;
    if (ctrl_i.shift) begin
      val_d = prev_val_i;
    end else if (ctrl_i.load) begin
      if (!active_i) begin
        val_d = '0;
      end else if (lt_o && !prev_lt_i) begin
        val_d = weight_i;
      end else if (prev_lt_i) begin
        val_d = prev_val_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      val_q <= '0;
    end else begin
      val_q <= val_d;
    end
  end

endmodule

### rtl/top_k_sum_threshold_check.sv
// ----------------------------------------------------------------------------
// top_k_sum_threshold_check
// Keeps the k largest weights of a group in a row of sorted cells; at group
// end drains the row into an adder and reports the sum against capacity.
// ----------------------------------------------------------------------------
// Throughput: one weight per cycle inside a group.
// Group end: the input stalls while the cell row drains, tail first, through
// the accumulator; the result is loaded into the output register once that is
// free, and the input takes the next weight after that.
// Reset: asynchronous; empties the store, capacity and k to reset values.
// ----------------------------------------------------------------------------
module top_k_sum_threshold_check #(
  parameter int unsigned MAX_SLOTS   = tksc_pkg::MAX_SLOTS_DEF,
  parameter int unsigned WEIGHT_BITS = tksc_pkg::WEIGHT_BITS_DEF,
  localparam int unsigned S_DATA_BITS = ((WEIGHT_BITS + 7) / 8) * 8
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [tksc_pkg::CFG_IDX_BITS-1:0]  cfg_index_i,
  input  logic [tksc_pkg::CFG_DATA_BITS-1:0] cfg_data_i,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  input  logic [S_DATA_BITS-1:0]             s_axis_tdata,  // weight
  input  logic                               s_axis_tlast,  // group_end
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  output logic [tksc_pkg::M_DATA_BITS-1:0]   m_axis_tdata   // fits, kept_sum
);

  localparam int unsigned KW       = $clog2(MAX_SLOTS + 1);
  localparam int unsigned SUM_BITS = WEIGHT_BITS + $clog2(MAX_SLOTS + 1);
  localparam int unsigned CMP_BITS = (SUM_BITS > tksc_pkg::CAP_BITS) ?
                                     SUM_BITS : tksc_pkg::CAP_BITS;
  localparam int unsigned KS       = tksc_pkg::KEPT_SUM_BITS;

  localparam logic ST_RUN   = 1'b0;
  localparam logic ST_DRAIN = 1'b1;

  logic [tksc_pkg::CAP_BITS-1:0]  capacity_q;
  logic [tksc_pkg::SLOT_BITS-1:0] slots_q;
  logic                           state_q, state_d;
  logic [KW-1:0]                  cnt_q, cnt_d;
  logic [SUM_BITS-1:0]            acc_q, acc_d;
  logic                           m_valid_q, m_valid_d;
  logic                           fits_q, fits_d;
  logic [KS-1:0]                  ksum_q, ksum_d;

  logic [KW-1:0]          k_eff;
  logic                   s_acc, out_free, drain_done;
  logic [WEIGHT_BITS-1:0] weight;
  logic [CMP_BITS-1:0]    acc_ext;
  tksc_pkg::cell_ctrl_t   ctrl;

  logic [WEIGHT_BITS-1:0] val [MAX_SLOTS];
  logic                   lt  [MAX_SLOTS];

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = (state_q == ST_RUN);
  assign s_acc         = s_axis_tvalid && s_axis_tready;
  assign weight        = s_axis_tdata[WEIGHT_BITS-1:0];
  assign out_free      = !m_valid_q || m_axis_tready;
  assign drain_done    = (cnt_q == KW'(MAX_SLOTS));

  always_comb begin
    if (slots_q == '0) begin
      k_eff = KW'(1);
    end else if (32'(slots_q) > MAX_SLOTS) begin
      k_eff = KW'(MAX_SLOTS);
    end else begin
      k_eff = KW'(slots_q);
    end
  end

  assign ctrl.load  = s_acc;
  assign ctrl.shift = (state_q == ST_DRAIN) && !drain_done;

  for (genvar i = 0; i < MAX_SLOTS; i++) begin : g_cell
    logic [WEIGHT_BITS-1:0] pv;
    logic                   pl;
    if (i == 0) begin : g_head
      assign pv = '0;
      assign pl = 1'b0;
    end else begin : g_link
      assign pv = val[i-1];
      assign pl = lt[i-1];
    end
    tksc_cell #(
      .WEIGHT_BITS(WEIGHT_BITS)
    ) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctrl_i     (ctrl),
      .active_i   (KW'(i) < k_eff),
      .weight_i   (weight),
      .prev_val_i (pv),
      .prev_lt_i  (pl),
      .val_o      (val[i]),
      .lt_o       (lt[i])
    );
  end

  assign acc_ext = CMP_BITS'(acc_q);

  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    acc_d     = acc_q;
    m_valid_d = m_valid_q && !m_axis_tready;
    fits_d    = fits_q;
    ksum_d    = ksum_q;
    case (state_q)
      ST_RUN: begin
        if (s_acc && s_axis_tlast) begin
          state_d = ST_DRAIN;
          cnt_d   = '0;
          acc_d   = '0;
        end
      end
      ST_DRAIN: begin
        if (!drain_done) begin
          acc_d = acc_q + SUM_BITS'(val[MAX_SLOTS-1]);
          cnt_d = cnt_q + KW'(1);
        end else if (out_free) begin
          m_valid_d = 1'b1;
          fits_d    = (acc_ext <= CMP_BITS'(capacity_q));
          ksum_d    = (acc_ext > CMP_BITS'({KS{1'b1}})) ? {KS{1'b1}} : acc_ext[KS-1:0];
          state_d   = ST_RUN;
        end
      end
      default: state_d = ST_RUN;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      capacity_q <= tksc_pkg::CAPACITY_RST;
      slots_q    <= tksc_pkg::SLOTS_RST;
      state_q    <= ST_RUN;
      cnt_q      <= '0;
      acc_q      <= '0;
      m_valid_q  <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        case (cfg_index_i)
          tksc_pkg::REG_CAPACITY: capacity_q <= cfg_data_i[tksc_pkg::CAP_BITS-1:0];
          tksc_pkg::REG_SLOTS:    slots_q    <= cfg_data_i[tksc_pkg::SLOT_BITS-1:0];
          default: ;
        endcase
      end
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      acc_q     <= acc_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    fits_q <= fits_d;
    ksum_q <= ksum_d;
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {{(tksc_pkg::M_DATA_BITS - KS - 1){1'b0}}, ksum_q, fits_q};

endmodule
